>>> hw/rtl/ttl_kvt_pkg.sv
// ----------------------------------------------------------------------------
// ttl_kvt_pkg
// Shared types and constants of the key-value table with expiry: table size,
// operation and status codes, controller states and the control interface.
// ----------------------------------------------------------------------------
package ttl_kvt_pkg;

   localparam int ENTRIES  = 16;
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int KEY_W    = 32;
   localparam int VALUE_W  = 32;
   localparam int TICK_W   = 31;

   typedef enum logic [1:0] {
      FN_PUT  = 2'd0,
      FN_GET  = 2'd1,
      FN_DEL  = 2'd2,
      FN_TICK = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      RS_HIT  = 2'd0,
      RS_MISS = 2'd1,
      RS_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [TICK_W-1:0]  expiry;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_en;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic rsp_busy;
   } stat_type;

endpackage

>>> hw/rtl/ttl_kvt_ctrl.sv
// ----------------------------------------------------------------------------
// ttl_kvt_ctrl
// Controller: accepts a request word, runs the table scan and schedules the
// write-back and response load in the datapath.
// ----------------------------------------------------------------------------
module ttl_kvt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_func,
   output logic                  req_ready,
   input  ttl_kvt_pkg::stat_type stat,
   output ttl_kvt_pkg::cmd_type  cmd
);
   import ttl_kvt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // A tick completes in the datapath at the accept edge.
               if (func_type'(req_func) != FN_TICK) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // Wait until the response register can take the new word.
            if (!stat.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/ttl_kvt_dp.sv
// ----------------------------------------------------------------------------
// ttl_kvt_dp
// Datapath: request registers, tick counter, entry memory with valid bits,
// the pipelined compare stage of the scan and the response register.
// ----------------------------------------------------------------------------
module ttl_kvt_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [1:0]                             req_func,
   input  logic signed [ttl_kvt_pkg::KEY_W-1:0]   req_key,
   input  logic signed [ttl_kvt_pkg::VALUE_W-1:0] req_value,
   input  logic [ttl_kvt_pkg::TICK_W-1:0]         req_expiry,
   input  ttl_kvt_pkg::cmd_type                   cmd,
   output ttl_kvt_pkg::stat_type                  stat,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_status,
   output logic signed [ttl_kvt_pkg::VALUE_W-1:0] rsp_read_value
);
   import ttl_kvt_pkg::*;

   // Request registers.
   func_type            func_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [TICK_W-1:0]   expiry_ff;

   logic [TICK_W-1:0]   now_ff;
   logic [TICK_W-1:0]   now_in;

   // Entry storage.
   entry_type           mem [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff;
   logic [ENTRIES-1:0]  valid_in;
   logic                mem_we;
   logic [IDX_W-1:0]    wr_addr;
   logic [IDX_W-1:0]    rd_addr;
   entry_type           rd_entry_ff;
   logic                rd_valid_ff;

   // Scan pipeline.
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    cnt_in;
   logic                issue;
   logic                cmp_vld_ff;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic                match;
   logic                free;

   logic                hit_ff;
   logic                hit_in;
   logic [IDX_W-1:0]    hit_idx_ff;
   logic [IDX_W-1:0]    hit_idx_in;
   logic [VALUE_W-1:0]  hit_value_ff;
   logic [VALUE_W-1:0]  hit_value_in;
   logic [TICK_W-1:0]   hit_expiry_ff;
   logic [TICK_W-1:0]   hit_expiry_in;
   logic                free_found_ff;
   logic                free_found_in;
   logic [IDX_W-1:0]    free_idx_ff;
   logic [IDX_W-1:0]    free_idx_in;

   // Response register.
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   status_type          rsp_status_ff;
   status_type          rsp_status_in;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [VALUE_W-1:0]  rsp_value_in;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= func_type'(req_func);
         key_ff    <= req_key;
         value_ff  <= req_value;
         expiry_ff <= req_expiry;
      end
   end

   always_comb begin
      now_in = now_ff;
      if (cmd.load && func_type'(req_func) == FN_TICK && now_ff != '1) begin
         now_in = now_ff + TICK_W'(1);
      end
   end

   // Scan: one entry is read per cycle and compared in the next.
   assign issue   = cmd.scan_en && (cnt_ff != CNT_W'(ENTRIES));
   assign rd_addr = cnt_ff[IDX_W-1:0];

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   assign match = cmp_vld_ff && rd_valid_ff && (rd_entry_ff.key == key_ff);
   assign free  = cmp_vld_ff && !rd_valid_ff;

   always_comb begin
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_value_in  = hit_value_ff;
      hit_expiry_in = hit_expiry_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (cmd.load) begin
         hit_in        = 1'b0;
         free_found_in = 1'b0;
      end else begin
         // Keys are unique among valid entries, so at most one match occurs.
         if (match) begin
            hit_in        = 1'b1;
            hit_idx_in    = cmp_idx_ff;
            hit_value_in  = rd_entry_ff.value;
            hit_expiry_in = rd_entry_ff.expiry;
         end
         if (free && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
      end
   end

   assign stat.scan_done = (cnt_ff == CNT_W'(ENTRIES)) && !cmp_vld_ff;
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_ready;

   // Write-back and response word.
   always_comb begin
      mem_we        = 1'b0;
      wr_addr       = hit_ff ? hit_idx_ff : free_idx_ff;
      valid_in      = valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = RS_MISS;
         rsp_value_in  = '0;
         case (func_ff)
            FN_PUT: begin
               if (hit_ff || free_found_ff) begin
                  mem_we            = 1'b1;
                  valid_in[wr_addr] = 1'b1;
                  rsp_status_in     = RS_HIT;
               end else begin
                  rsp_status_in = RS_FULL;
               end
            end
            FN_GET: begin
               if (hit_ff && hit_expiry_ff >= now_ff) begin
                  rsp_status_in = RS_HIT;
                  rsp_value_in  = hit_value_ff;
               end
            end
            FN_DEL: begin
               if (hit_ff) begin
                  valid_in[hit_idx_ff] = 1'b0;
                  rsp_status_in        = RS_HIT;
               end
            end
            default: begin
               rsp_status_in = RS_MISS;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= '{key: key_ff, value: value_ff, expiry: expiry_ff};
      end
      rd_entry_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      rd_valid_ff   <= valid_ff[rd_addr];
      cmp_idx_ff    <= rd_addr;
      hit_idx_ff    <= hit_idx_in;
      hit_value_ff  <= hit_value_in;
      hit_expiry_ff <= hit_expiry_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff        <= '0;
         valid_ff      <= '0;
         cnt_ff        <= '0;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         now_ff        <= now_in;
         valid_ff      <= valid_in;
         cnt_ff        <= cnt_in;
         cmp_vld_ff    <= issue;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;

`ifndef SYNTH
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response overwritten before it was taken");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(ENTRIES))
      else $error("scan counter beyond table size");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("response word without a commit");

   a_cmp_from_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> $past(cmd.scan_en))
      else $error("compare stage active outside a scan");
`endif

endmodule

>>> hw/rtl/ttl_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// ttl_key_value_table_unit
// Key-value table of sixteen entries with per-entry expiry tick.
// ----------------------------------------------------------------------------
// Usage: a request word on the req_ channel carries an operation (put, get,
// delete or tick), a key, a value and an absolute expiry tick. Put, get and
// delete each return one response word on the rsp_ channel with a status
// (hit, miss or table full) and, on a get hit, the stored value. A tick
// advances the internal time counter and returns no word.
// A tick is taken and done in the cycle of its accept. Any other request scans
// every entry of the table memory, one read per cycle plus one compare stage,
// then writes back; the next request is taken only once the controller is
// back in idle after the write-back. The scan runs through the single read
// port of the entry memory.
// The response sits in an output register: if the receiver stalls, the next
// request is still accepted and scanned, and only its write-back waits until
// the pending word is taken.
// Reset clears the time counter, all entry valid bits and the response valid flag.
// ----------------------------------------------------------------------------
module ttl_key_value_table_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_func,
   input  logic signed [ttl_kvt_pkg::KEY_W-1:0]   req_key,
   input  logic signed [ttl_kvt_pkg::VALUE_W-1:0] req_value,
   input  logic [ttl_kvt_pkg::TICK_W-1:0]         req_expiry,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_status,
   output logic signed [ttl_kvt_pkg::VALUE_W-1:0] rsp_read_value
);
   import ttl_kvt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ttl_kvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ttl_kvt_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_func       (req_func),
      .req_key        (req_key),
      .req_value      (req_value),
      .req_expiry     (req_expiry),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value)
   );

endmodule

>>> sim/ttl_key_value_table_unit_tb.sv
// ----------------------------------------------------------------------------
// ttl_key_value_table_unit_tb
// Self-checking bench for the key-value table with per-entry expiry. A short
// directed run covers the empty, expired, overwrite and full-table cases.
// Random put, get, delete and tick words follow, drawn from key pools of
// varying size. A predictor of the table checks every response word, while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module ttl_key_value_table_unit_tb;
   import ttl_kvt_pkg::*;

   localparam int RANDOM_WORDS = 1500;
   localparam int STALL_LIMIT  = 5000;

   typedef struct {
      func_type             func;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
      logic [TICK_W-1:0]    expiry;
   } table_req_type;

   typedef struct {
      status_type           status;
      logic [VALUE_W-1:0]   read_value;
   } table_outcome_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [1:0]                   req_func = FN_TICK;
   logic signed [KEY_W-1:0]      req_key = '0;
   logic signed [VALUE_W-1:0]    req_value = '0;
   logic [TICK_W-1:0]            req_expiry = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [1:0]                   rsp_status;
   logic signed [VALUE_W-1:0]    rsp_read_value;

   ttl_key_value_table_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_key        (req_key),
      .req_value      (req_value),
      .req_expiry     (req_expiry),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Predicted table contents.
   logic                 tbl_valid  [ENTRIES];
   logic [KEY_W-1:0]     tbl_key    [ENTRIES];
   logic [VALUE_W-1:0]   tbl_value  [ENTRIES];
   logic [TICK_W-1:0]    tbl_expiry [ENTRIES];
   logic [TICK_W-1:0]    tick_count = '0;

   table_req_type       request_q [$];
   table_outcome_type   outcome_q [$];
   table_req_type       next_req;

   logic             req_taken = 1'b0;
   logic             quiet = 1'b0;
   int               failures = 0;
   int               gen_ticks = 0;
   int               pool_size = 8;
   logic [KEY_W-1:0] key_pool [32];

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
      end
   end

   task automatic apply_request(input table_req_type rq);
      int                slot;
      int                spare;
      table_outcome_type res;
      slot = -1;
      spare = -1;
      if (rq.func == FN_TICK) begin
         if (tick_count != {TICK_W{1'b1}}) tick_count = tick_count + 1'b1;
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_key[i] == rq.key && slot < 0) slot = i;
            if (!tbl_valid[i] && spare < 0) spare = i;
         end
         res.status = RS_MISS;
         res.read_value = '0;
         case (rq.func)
            FN_PUT: begin
               if (slot < 0) slot = spare;
               if (slot < 0) begin
                  res.status = RS_FULL;
               end else begin
                  tbl_valid[slot] = 1'b1;
                  tbl_key[slot] = rq.key;
                  tbl_value[slot] = rq.value;
                  tbl_expiry[slot] = rq.expiry;
                  res.status = RS_HIT;
               end
            end
            FN_GET: begin
               if (slot >= 0 && tbl_expiry[slot] >= tick_count) begin
                  res.status = RS_HIT;
                  res.read_value = tbl_value[slot];
               end
            end
            default: begin
               if (slot >= 0) begin
                  tbl_valid[slot] = 1'b0;
                  res.status = RS_HIT;
               end
            end
         endcase
         outcome_q.insert(outcome_q.size(), res);
      end
   endtask

   task automatic queue_req(input func_type f, input logic [KEY_W-1:0] k,
                            input logic [VALUE_W-1:0] v, input logic [TICK_W-1:0] e);
      table_req_type rq;
      rq.func = f;
      rq.key = k;
      rq.value = v;
      rq.expiry = e;
      request_q.insert(request_q.size(), rq);
      if (f == FN_TICK) gen_ticks++;
   endtask

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // Expiry mostly lands near the time the word will see, so that both
   // live and expired entries are common.
   function automatic logic [TICK_W-1:0] pick_expiry();
      int r;
      int t;
      r = $urandom_range(0, 99);
      t = gen_ticks + $urandom_range(0, 8) - 2;
      if (t < 0) t = 0;
      if (r < 10) return TICK_W'($urandom);
      else if (r < 15) return '0;
      else if (r < 20) return {TICK_W{1'b1}};
      else return TICK_W'(t);
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 9) == 0) return $urandom;
      else return key_pool[$urandom_range(0, pool_size - 1)];
   endfunction

   // Driver: presents one request word at a time, with random gaps.
   int gap_left = 0;
   int sent_count = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (request_q.size() > 0) begin
            next_req = request_q.pop_front();
            req_func <= next_req.func;
            req_key <= next_req.key;
            req_value <= next_req.value;
            req_expiry <= next_req.expiry;
            req_valid <= 1'b1;
            sent_count++;
            if (sent_count % 100 == 0) quiet <= ($urandom_range(0, 3) == 0);
            gap_left = quiet ? 0 : pick_idle();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stalls.
   int stall_left = 0;

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!reset && !quiet && $urandom_range(0, 9) == 0) stall_left = pick_idle();
      end
   end

   // Monitor: checks response words, then predicts the accepted request.
   always @(posedge clock) begin
      table_outcome_type want;
      table_req_type     seen;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $error("response word with no request outstanding");
               failures++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  failures++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected %0h, got %0h",
                         want.read_value, rsp_read_value);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            seen.func = func_type'(req_func);
            seen.key = req_key;
            seen.value = req_value;
            seen.expiry = req_expiry;
            apply_request(seen);
         end
      end
   end

   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int r;
      // Empty table, then the extreme keys, values and expiry ticks.
      queue_req(FN_GET, 32'hFFFF_FFFF, 32'h0, '0);
      queue_req(FN_DEL, 32'h0, 32'h0, '0);
      queue_req(FN_PUT, 32'h8000_0000, 32'h7FFF_FFFF, {TICK_W{1'b1}});
      queue_req(FN_PUT, 32'h7FFF_FFFF, 32'h8000_0000, '0);
      queue_req(FN_GET, 32'h7FFF_FFFF, 32'h0, '0);
      queue_req(FN_TICK, $urandom, $urandom, TICK_W'($urandom));
      queue_req(FN_GET, 32'h7FFF_FFFF, 32'h0, '0);
      // Overwrite an expired entry, then delete it.
      queue_req(FN_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 31'd1);
      queue_req(FN_GET, 32'h7FFF_FFFF, 32'h0, '0);
      queue_req(FN_DEL, 32'h7FFF_FFFF, 32'h0, '0);
      queue_req(FN_GET, 32'h7FFF_FFFF, 32'h0, '0);
      // Fill the table; a new key is then refused but an overwrite is not.
      for (int i = 0; i < ENTRIES - 1; i++) begin
         queue_req(FN_PUT, i, $urandom, 31'd1000);
      end
      queue_req(FN_PUT, 32'h1234_5678, 32'h5555_AAAA, 31'd50);
      queue_req(FN_PUT, 32'h8000_0000, 32'h0, '0);
      queue_req(FN_DEL, 32'h8000_0000, 32'h0, '0);
      queue_req(FN_PUT, 32'h1234_5678, 32'hAAAA_5555, 31'd50);

      key_pool[0] = 32'h0;
      key_pool[1] = 32'h1;
      key_pool[2] = 32'h2;
      key_pool[3] = 32'hFFFF_FFFF;
      key_pool[4] = 32'h8000_0000;
      key_pool[5] = 32'h7FFF_FFFF;
      key_pool[6] = 32'h1234_5678;
      key_pool[7] = 32'h3;
      for (int i = 8; i < 32; i++) begin
         key_pool[i] = $urandom;
      end

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // Small pools give many hits; large ones keep the table full.
         if (n % 250 == 0) pool_size = $urandom_range(6, 32);
         r = $urandom_range(0, 99);
         if (r < 35) queue_req(FN_PUT, pick_key(), $urandom, pick_expiry());
         else if (r < 65) queue_req(FN_GET, pick_key(), $urandom, TICK_W'($urandom));
         else if (r < 80) queue_req(FN_DEL, pick_key(), $urandom, TICK_W'($urandom));
         else queue_req(FN_TICK, $urandom, $urandom, TICK_W'($urandom));
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || req_valid) @(posedge clock);
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/ttl_kvt_pkg.sv
hw/rtl/ttl_kvt_ctrl.sv
hw/rtl/ttl_kvt_dp.sv
hw/rtl/ttl_key_value_table_unit.sv
sim/ttl_key_value_table_unit_tb.sv
